/* hw/rtl/mdc_pkg.sv */
`timescale 1ns / 1ps
// Shared codes and the command and status structs of the maze carver.
package mdc_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] GRID_FLOOR = 2'd0;
    localparam logic [1:0] GRID_WALL  = 2'd1;
    localparam logic [1:0] GRID_GOAL  = 2'd2;

    typedef struct packed {
        logic latch;
        logic clear_en;
        logic init;
        logic probe_rd;
        logic probe_chk;
        logic choose;
        logic carve_mid;
        logic carve_tgt;
        logic pop;
        logic pop_load;
        logic goal;
        logic read_rd;
        logic read_cap;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       clear_last;
        logic       stack_empty;
        logic       probe_last;
        logic       cand_any;
        logic       pop_to_empty;
        logic       in_map;
        logic       done;
        logic [1:0] res_tile;
        logic       res_walk;
    } dp_stat_t;

endpackage

/* hw/rtl/maze_dfs_carver.sv */
`timescale 1ns / 1ps
// Top level of the depth-first maze carver with its result register.
// The block handles one word at a time; every accepted word yields one result word.
// After reset the tile memory is swept to wall, one tile per cycle, while s_tready
// stays low. A start word runs the same sweep and then opens the start tile. A step
// word reads its four neighbor tiles one after the other through the single read
// port of the tile memory, then carves or backs up; a step on an empty stack skips
// the probes. A read word reads one tile and captures it; any other action code
// goes straight to the result. The next word is accepted once the result is
// registered, even while m_tvalid still waits for m_tready.
module maze_dfs_carver #(
    parameter int MAP_WIDTH  = 50,
    parameter int MAP_HEIGHT = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rand_value[15:0], grid_x[23:16], grid_y[31:24]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // tile[1:0], walkable[2], finished[3], zero[7:4]
);

    mdc_pkg::dp_cmd_t  cmd;
    mdc_pkg::dp_stat_t stat;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    mdc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd)
    );

    mdc_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {4'b0000, stat.done, stat.res_walk, stat.res_tile};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A start always leaves the maze unfinished.
    a_start_unfinished: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && stat.action == mdc_pkg::ACT_START |=> !m_tdata[3])
        else $error("start result reports finished");

    // A read outside the map returns a wall that cannot be walked on.
    a_read_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && stat.action == mdc_pkg::ACT_READ && !stat.in_map |=>
        m_tdata[1:0] == mdc_pkg::GRID_WALL && !m_tdata[2])
        else $error("read outside the map is not a plain wall");

    // A wall is never reported as walkable.
    a_wall_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[1:0] == mdc_pkg::GRID_WALL))
        else $error("wall reported walkable");

    // No new word enters while a result is still being assembled.
    a_no_accept_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("input accepted while result is emitted");

endmodule

/* hw/rtl/mdc_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the maze carver: tile memory, coordinate stack and step registers.
module mdc_datapath #(
    parameter int MAP_WIDTH  = 50,
    parameter int MAP_HEIGHT = 30
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       in_action,
    input  logic [31:0]      in_data,
    input  mdc_pkg::dp_cmd_t cmd,
    output mdc_pkg::dp_stat_t stat
);

    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int SAW   = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int CRD_W = 9;

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic signed [2:0] offs_t;

    localparam offs_t STEP_DX [4] = '{3'sd0, 3'sd2, 3'sd0, -3'sd2};
    localparam offs_t STEP_DY [4] = '{-3'sd2, 3'sd0, 3'sd2, 3'sd0};
    localparam offs_t MID_DX  [4] = '{3'sd0, 3'sd1, 3'sd0, -3'sd1};
    localparam offs_t MID_DY  [4] = '{-3'sd1, 3'sd0, 3'sd1, 3'sd0};

    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    function automatic logic [1:0] pick_dir(input logic [3:0] mask, input logic [1:0] k);
        logic [1:0] res;
        logic [2:0] cnt;
        res = '0;
        cnt = '0;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (cnt == {1'b0, k}) begin
                    res = 2'(i);
                end
                cnt = cnt + 3'd1;
            end
        end
        return res;
    endfunction

    logic [1:0]          tile_mem [CELLS];
    logic [XW+YW-1:0]    stk_mem  [CELLS];

    logic [1:0]          act_reg;
    logic [15:0]         rand_reg;
    logic [7:0]          gx_reg, gy_reg;
    logic [XW-1:0]       cx_reg;
    logic [YW-1:0]       cy_reg;
    logic [CNTW-1:0]     count_reg;
    logic                done_reg;
    logic [1:0]          dir_reg;
    logic [3:0]          mask_reg;
    logic                inb_reg;
    logic                in_map_reg;
    logic [1:0]          sel_reg;
    logic [SAW-1:0]      sweep_reg;
    logic [1:0]          tile_q_reg;
    logic [XW+YW-1:0]    stk_q_reg;
    logic [1:0]          res_tile_reg;
    logic                res_walk_reg;

    crd_t            cx_s, cy_s, sx, sy, px, py;
    logic            sel_ok, probe_inb;
    logic [SAW-1:0]  lin_addr, waddr;
    logic            tile_we, tile_re;
    logic [1:0]      tile_wdata;
    logic [2:0]      n_cand;
    logic [1:0]      k_idx;

    assign cx_s = $signed({{(CRD_W-XW){1'b0}}, cx_reg});
    assign cy_s = $signed({{(CRD_W-YW){1'b0}}, cy_reg});
    assign px   = cx_s + CRD_W'(STEP_DX[dir_reg]);
    assign py   = cy_s + CRD_W'(STEP_DY[dir_reg]);

    assign probe_inb = (px > crd_t'(0)) && (px < crd_t'(MAP_WIDTH - 1)) &&
                       (py > crd_t'(0)) && (py < crd_t'(MAP_HEIGHT - 1));

    always_comb begin
        sx = '0;
        sy = '0;
        if (cmd.init) begin
            sx = crd_t'(1);
            sy = crd_t'(1);
        end else if (cmd.probe_rd) begin
            sx = px;
            sy = py;
        end else if (cmd.carve_mid) begin
            sx = cx_s + CRD_W'(MID_DX[sel_reg]);
            sy = cy_s + CRD_W'(MID_DY[sel_reg]);
        end else if (cmd.carve_tgt) begin
            sx = cx_s + CRD_W'(STEP_DX[sel_reg]);
            sy = cy_s + CRD_W'(STEP_DY[sel_reg]);
        end else if (cmd.goal) begin
            sx = crd_t'(MAP_WIDTH - 2);
            sy = crd_t'(MAP_HEIGHT - 2);
        end else if (cmd.read_rd) begin
            sx = crd_t'($signed(gx_reg));
            sy = crd_t'($signed(gy_reg));
        end
    end

    assign sel_ok = (sx >= crd_t'(0)) && (sx < crd_t'(MAP_WIDTH)) &&
                    (sy >= crd_t'(0)) && (sy < crd_t'(MAP_HEIGHT));

    assign lin_addr = sel_ok ? SAW'(sy[YW-1:0] * MAP_WIDTH) + SAW'(sx[XW-1:0]) : '0;
    assign waddr    = cmd.clear_en ? sweep_reg : lin_addr;
    assign tile_we  = cmd.clear_en | cmd.init | cmd.carve_mid | cmd.carve_tgt | cmd.goal;
    assign tile_re  = cmd.probe_rd | cmd.read_rd;

    always_comb begin
        if (cmd.clear_en) begin
            tile_wdata = mdc_pkg::GRID_WALL;
        end else if (cmd.goal) begin
            tile_wdata = mdc_pkg::GRID_GOAL;
        end else begin
            tile_wdata = mdc_pkg::GRID_FLOOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[waddr] <= tile_wdata;
        end
        if (tile_re) begin
            tile_q_reg <= tile_mem[lin_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            stk_mem[SAW'(0)] <= {YW'(1), XW'(1)};
        end else if (cmd.carve_tgt && count_reg < CNTW'(CELLS)) begin
            stk_mem[count_reg[SAW-1:0]] <= {sy[YW-1:0], sx[XW-1:0]};
        end
        if (cmd.pop) begin
            stk_q_reg <= stk_mem[SAW'(count_reg - CNTW'(2))];
        end
    end

    assign n_cand = 3'(mask_reg[0]) + 3'(mask_reg[1]) + 3'(mask_reg[2]) + 3'(mask_reg[3]);

    always_comb begin
        case (n_cand)
            3'd2:    k_idx = {1'b0, rand_reg[0]};
            3'd3:    k_idx = mod3_16(rand_reg);
            3'd4:    k_idx = rand_reg[1:0];
            default: k_idx = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b1;
            sweep_reg <= '0;
        end else begin
            if (cmd.clear_en) begin
                sweep_reg <= (sweep_reg == SAW'(CELLS - 1)) ? '0 : sweep_reg + SAW'(1);
            end
            if (cmd.init) begin
                count_reg <= CNTW'(1);
                done_reg  <= 1'b0;
            end else if (cmd.carve_tgt && count_reg < CNTW'(CELLS)) begin
                count_reg <= count_reg + CNTW'(1);
            end else if (cmd.pop) begin
                count_reg <= count_reg - CNTW'(1);
            end
            if (cmd.goal) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg      <= in_action;
            rand_reg     <= in_data[15:0];
            gx_reg       <= in_data[23:16];
            gy_reg       <= in_data[31:24];
            dir_reg      <= '0;
            mask_reg     <= '0;
            res_tile_reg <= '0;
            res_walk_reg <= 1'b0;
        end
        if (cmd.init) begin
            cx_reg <= XW'(1);
            cy_reg <= YW'(1);
        end
        if (cmd.probe_rd) begin
            inb_reg <= probe_inb;
        end
        if (cmd.probe_chk) begin
            mask_reg[dir_reg] <= inb_reg && (tile_q_reg == mdc_pkg::GRID_WALL);
            dir_reg           <= dir_reg + 2'd1;
        end
        if (cmd.choose) begin
            sel_reg <= pick_dir(mask_reg, k_idx);
        end
        if (cmd.carve_tgt && count_reg < CNTW'(CELLS)) begin
            cx_reg <= sx[XW-1:0];
            cy_reg <= sy[YW-1:0];
        end
        if (cmd.pop_load) begin
            cx_reg <= stk_q_reg[XW-1:0];
            cy_reg <= stk_q_reg[XW+YW-1:XW];
        end
        if (cmd.read_rd) begin
            in_map_reg <= sel_ok;
        end
        if (cmd.read_cap) begin
            if (in_map_reg) begin
                res_tile_reg <= tile_q_reg;
                res_walk_reg <= (tile_q_reg == mdc_pkg::GRID_FLOOR) ||
                                (tile_q_reg == mdc_pkg::GRID_GOAL);
            end else begin
                res_tile_reg <= mdc_pkg::GRID_WALL;
                res_walk_reg <= 1'b0;
            end
        end
    end

    assign stat.action       = act_reg;
    assign stat.clear_last   = (sweep_reg == SAW'(CELLS - 1));
    assign stat.stack_empty  = (count_reg == '0);
    assign stat.probe_last   = (dir_reg == 2'd3);
    assign stat.cand_any     = (mask_reg != 4'd0);
    assign stat.pop_to_empty = (count_reg == CNTW'(1));
    assign stat.in_map       = in_map_reg;
    assign stat.done         = done_reg;
    assign stat.res_tile     = res_tile_reg;
    assign stat.res_walk     = res_walk_reg;

endmodule

/* hw/rtl/mdc_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the maze carver.
module mdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        in_action,
    output logic              in_ready,
    input  logic              out_free,
    input  mdc_pkg::dp_stat_t stat,
    output mdc_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_BOOT_CLEAR,
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_STEP,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CHOOSE,
        S_CARVE_MID,
        S_CARVE_TGT,
        S_POP_LOAD,
        S_GOAL,
        S_READ_RD,
        S_READ_CAP,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_BOOT_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch = 1'b1;
                    unique case (in_action)
                        mdc_pkg::ACT_START: state_next = S_CLEAR;
                        mdc_pkg::ACT_STEP:  state_next = S_STEP;
                        mdc_pkg::ACT_READ:  state_next = S_READ_RD;
                        default:            state_next = S_RESULT;
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_RESULT;
            end
            S_STEP: begin
                state_next = stat.stack_empty ? S_RESULT : S_PROBE_RD;
            end
            S_PROBE_RD: begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                cmd.probe_chk = 1'b1;
                state_next    = stat.probe_last ? S_CHOOSE : S_PROBE_RD;
            end
            S_CHOOSE: begin
                if (stat.cand_any) begin
                    cmd.choose = 1'b1;
                    state_next = S_CARVE_MID;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = stat.pop_to_empty ? S_GOAL : S_POP_LOAD;
                end
            end
            S_CARVE_MID: begin
                cmd.carve_mid = 1'b1;
                state_next    = S_CARVE_TGT;
            end
            S_CARVE_TGT: begin
                cmd.carve_tgt = 1'b1;
                state_next    = S_RESULT;
            end
            S_POP_LOAD: begin
                cmd.pop_load = 1'b1;
                state_next   = S_RESULT;
            end
            S_GOAL: begin
                cmd.goal   = 1'b1;
                state_next = S_RESULT;
            end
            S_READ_RD: begin
                cmd.read_rd = 1'b1;
                state_next  = S_READ_CAP;
            end
            S_READ_CAP: begin
                cmd.read_cap = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
